// File: src/srb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_pkg: shared definitions for the sequence reorder buffer
// Cache geometry, action codes, controller-to-datapath operations,
// register indexes and the delivery classification function.
// ----------------------------------------------------------------------------
package srb_pkg;

    localparam int CACHE_DEPTH = 32;
    localparam int TAG_BITS    = 8;
    localparam int SLOT_IDX_W  = $clog2(CACHE_DEPTH);
    localparam int OCC_W       = $clog2(CACHE_DEPTH + 1);
    localparam int SEQ_W       = 16;
    localparam int FLAG_W      = 5;
    localparam int ACT_W       = 4;
    localparam int TRK_W       = 2;
    localparam int GU_W        = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int WRAP_CUTOFF = 1024;

    // flag bit positions
    localparam int F_ACK  = 0;
    localparam int F_FRAG = 1;
    localparam int F_CHI  = 2;
    localparam int F_CLO  = 3;
    localparam int F_OPC  = 4;

    // actions
    localparam logic [ACT_W-1:0] ACT_PAYLOAD  = 4'd0;
    localparam logic [ACT_W-1:0] ACT_FRAGMENT = 4'd1;
    localparam logic [ACT_W-1:0] ACT_PING     = 4'd2;
    localparam logic [ACT_W-1:0] ACT_CLOSING  = 4'd3;
    localparam logic [ACT_W-1:0] ACT_CACHED   = 4'd4;
    localparam logic [ACT_W-1:0] ACT_STALE    = 4'd5;
    localparam logic [ACT_W-1:0] ACT_OVERFLOW = 4'd6;
    localparam logic [ACT_W-1:0] ACT_LOCK     = 4'd7;
    localparam logic [ACT_W-1:0] ACT_REPLACED = 4'd8;
    localparam logic [ACT_W-1:0] ACT_NO_OPC   = 4'd9;

    // tracking levels
    localparam logic [TRK_W-1:0] TRK_OFF     = 2'd0;
    localparam logic [TRK_W-1:0] TRK_ON      = 2'd1;
    localparam logic [TRK_W-1:0] TRK_LATCHED = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GIVE_UP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACKING = 2'd2;

    // datapath operations
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_PRE       = 4'd2;
    localparam logic [3:0] OP_MAIN      = 4'd3;
    localparam logic [3:0] OP_SCAN_INIT = 4'd4;
    localparam logic [3:0] OP_SCAN      = 4'd5;
    localparam logic [3:0] OP_DSTEP     = 4'd6;
    localparam logic [3:0] OP_FIN       = 4'd7;

    typedef struct packed {
        logic [3:0] op;
    } srb_cmd_t;

    typedef struct packed {
        logic has_seq;
        logic main_close;
        logic occ_zero;
        logic give_up;
        logic scan_last;
        logic drain_hit;
        logic drain_close;
        logic put_ok;
        logic out_free;
    } srb_status_t;

    // action of a delivered sequenced packet
    function automatic logic [ACT_W-1:0] classify(input logic [FLAG_W-1:0] f,
                                                  input logic z2c);
        logic [ACT_W-1:0] a;
        if (!f[F_ACK] && !f[F_FRAG] && !f[F_CHI])
            a = ACT_PING;
        else if (f[F_CHI] && f[F_CLO] && z2c)
            a = ACT_CLOSING;
        else if (f[F_FRAG])
            a = ACT_FRAGMENT;
        else if (f[F_OPC])
            a = ACT_PAYLOAD;
        else
            a = ACT_NO_OPC;
        return a;
    endfunction

endpackage
`default_nettype wire

// File: src/sequence_reorder_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sequence_reorder_buffer: in-order delivery of sequenced packet descriptors
// Packets enter on the pkt channel (valid/stall) and results leave on the
// res channel (valid/stall); each packet gives one or more result beats,
// the final one marked by last. Registers must be written on the cfg channel
// (valid/ready, always ready) only while the block is idle; the block itself
// does not enforce this. An unsequenced packet goes straight to the final
// flush; a sequenced one skips the drain when it closes at once or the
// cache is empty, and otherwise drains one step per cached entry delivered.
// A give-up skip adds a scan of the cache, one slot per cycle. The last
// beat enters the output register in the final flush.
// The next packet is taken once the last beat is in the output register;
// a beat waiting there does not block it. When the receiver stalls, the
// block holds after staging one more beat until the output beat is taken.
// After reset the cache is empty, expected is 0, give_up_count is 32 and
// tracking is off; the cache is tracked by per-slot valid bits.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [srb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [srb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire                               pkt_valid,
    output logic                              pkt_stall,
    input  wire  [srb_pkg::TAG_BITS-1:0]      packet_tag,
    input  wire                               has_seq,
    input  wire  [srb_pkg::SEQ_W-1:0]         seq_num,
    input  wire                               seq_start,
    input  wire                               closing_hi,
    input  wire                               closing_lo,
    input  wire                               has_ack_seq,
    input  wire                               is_fragment,
    input  wire                               has_opcode,
    input  wire                               data_valid,
    output logic                              res_valid,
    input  wire                               res_stall,
    output logic [srb_pkg::ACT_W-1:0]         action,
    output logic [srb_pkg::TAG_BITS-1:0]      out_tag,
    output logic [srb_pkg::SEQ_W-1:0]         out_seq,
    output logic [srb_pkg::SEQ_W-1:0]         expected_seq,
    output logic [srb_pkg::TRK_W-1:0]         tracking_level,
    output logic                              last
);

    srb_pkg::srb_cmd_t    cmd;
    srb_pkg::srb_status_t sts;

    assign cfg_ready = 1'b1;

    // sequence the packet
    srb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // cache, state and result staging
    srb_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .packet_tag     (packet_tag),
        .has_seq        (has_seq),
        .seq_num        (seq_num),
        .seq_start      (seq_start),
        .closing_hi     (closing_hi),
        .closing_lo     (closing_lo),
        .has_ack_seq    (has_ack_seq),
        .is_fragment    (is_fragment),
        .has_opcode     (has_opcode),
        .data_valid     (data_valid),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .action         (action),
        .out_tag        (out_tag),
        .out_seq        (out_seq),
        .expected_seq   (expected_seq),
        .tracking_level (tracking_level),
        .last           (last)
    );

endmodule
`default_nettype wire

// File: src/srb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_ctrl: sequencing controller
// Steps one packet through latch, pre-step, main decision, drain and flush.
// ----------------------------------------------------------------------------
module srb_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  pkt_valid,
    output logic                 pkt_stall,
    input  srb_pkg::srb_status_t sts,
    output srb_pkg::srb_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRE   = 3'd1;
    localparam logic [2:0] S_MAIN  = 3'd2;
    localparam logic [2:0] S_D0    = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DSTEP = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign pkt_stall = (state_reg != S_IDLE);

    // choose next state and datapath operation
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = srb_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (pkt_valid)
                begin
                    cmd.op     = srb_pkg::OP_LOAD;
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                if (sts.put_ok)
                begin
                    cmd.op     = srb_pkg::OP_PRE;
                    state_next = sts.has_seq ? S_MAIN : S_FIN;
                end
            end
            S_MAIN:
            begin
                if (sts.put_ok)
                begin
                    cmd.op     = srb_pkg::OP_MAIN;
                    state_next = sts.main_close ? S_FIN : S_D0;
                end
            end
            S_D0:
            begin
                if (sts.occ_zero)
                    state_next = S_FIN;
                else if (sts.give_up)
                begin
                    cmd.op     = srb_pkg::OP_SCAN_INIT;
                    state_next = S_SCAN;
                end
                else
                    state_next = S_DSTEP;
            end
            S_SCAN:
            begin
                cmd.op = srb_pkg::OP_SCAN;
                if (sts.scan_last)
                    state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                if (!sts.drain_hit)
                    state_next = S_FIN;
                else if (sts.put_ok)
                begin
                    cmd.op = srb_pkg::OP_DSTEP;
                    if (sts.drain_close)
                        state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = srb_pkg::OP_FIN;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// File: src/srb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_datapath: cache, sequence state and result staging
// Holds the slot cache with parallel lookup, the expected counter, the
// registers, a pending result and the output register.
// ----------------------------------------------------------------------------
module srb_datapath (
    input  wire                               clk,
    input  wire                               rst_n,
    input  srb_pkg::srb_cmd_t                 cmd,
    output srb_pkg::srb_status_t              sts,
    input  wire                               cfg_valid,
    input  wire  [srb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [srb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire  [srb_pkg::TAG_BITS-1:0]      packet_tag,
    input  wire                               has_seq,
    input  wire  [srb_pkg::SEQ_W-1:0]         seq_num,
    input  wire                               seq_start,
    input  wire                               closing_hi,
    input  wire                               closing_lo,
    input  wire                               has_ack_seq,
    input  wire                               is_fragment,
    input  wire                               has_opcode,
    input  wire                               data_valid,
    output logic                              res_valid,
    input  wire                               res_stall,
    output logic [srb_pkg::ACT_W-1:0]         action,
    output logic [srb_pkg::TAG_BITS-1:0]      out_tag,
    output logic [srb_pkg::SEQ_W-1:0]         out_seq,
    output logic [srb_pkg::SEQ_W-1:0]         expected_seq,
    output logic [srb_pkg::TRK_W-1:0]         tracking_level,
    output logic                              last
);

    localparam int D  = srb_pkg::CACHE_DEPTH;
    localparam int IW = srb_pkg::SLOT_IDX_W;
    localparam int SW = srb_pkg::SEQ_W;
    localparam int TW = srb_pkg::TAG_BITS;
    localparam int FW = srb_pkg::FLAG_W;
    localparam int AW = srb_pkg::ACT_W;
    localparam int KW = srb_pkg::TRK_W;
    localparam int OW = srb_pkg::OCC_W;

    // latched packet
    logic [TW-1:0] tag_reg;
    logic          has_seq_reg;
    logic [SW-1:0] seq_reg;
    logic          start_reg;
    logic [FW-1:0] flags_reg;
    logic          dv_reg;

    // sequence state and registers
    logic [SW-1:0]           expected_reg, expected_next;
    logic                    known_reg, known_next;
    logic [KW-1:0]           track_reg, track_next;
    logic [srb_pkg::GU_W-1:0] gu_reg, gu_next;
    logic                    z2c_reg, z2c_next;
    logic [OW-1:0]           occ_reg, occ_next;
    logic [SW:0]             best_reg, best_next;
    logic [IW-1:0]           scan_idx_reg, scan_idx_next;

    // cache
    logic [D-1:0]  slot_valid_reg;
    logic [SW-1:0] slot_seq_reg   [D];
    logic [TW-1:0] slot_tag_reg   [D];
    logic [FW-1:0] slot_flags_reg [D];

    // pending result
    logic          pend_valid_reg;
    logic [AW-1:0] pend_act_reg;
    logic [TW-1:0] pend_tag_reg;
    logic [SW-1:0] pend_seq_reg;
    logic [SW-1:0] pend_exp_reg;
    logic [KW-1:0] pend_trk_reg;

    // output register
    logic          out_valid_reg;
    logic [AW-1:0] out_act_reg;
    logic [TW-1:0] out_tag_reg;
    logic [SW-1:0] out_seq_reg;
    logic [SW-1:0] out_exp_reg;
    logic [KW-1:0] out_trk_reg;
    logic          out_last_reg;

    // lookup results
    logic          hit_in, hit_exp, free_any;
    logic [IW-1:0] idx_in, idx_exp, free_idx;

    // put and slot write controls
    logic          put_en;
    logic [AW-1:0] put_act;
    logic [TW-1:0] put_tag;
    logic [SW-1:0] put_seq;
    logic [SW-1:0] put_exp;
    logic [KW-1:0] put_trk;
    logic          slot_upd, slot_new, slot_clr;
    logic [IW-1:0] wr_idx;

    logic          out_free;
    logic          push;
    logic [AW-1:0] main_act, drain_act;
    logic          ahead;
    logic [SW:0]   s17, e17;
    logic [SW-1:0] scan_d;
    logic [SW:0]   scan_cand;
    logic [KW-1:0] close_trk;

    // search the cache in parallel: lowest index wins
    always_comb
    begin
        hit_in   = 1'b0;
        hit_exp  = 1'b0;
        free_any = 1'b0;
        idx_in   = '0;
        idx_exp  = '0;
        free_idx = '0;
        for (int i = D - 1; i >= 0; i--)
        begin
            if (slot_valid_reg[i] && slot_seq_reg[i] == seq_reg)
            begin
                hit_in = 1'b1;
                idx_in = IW'(i);
            end
            if (slot_valid_reg[i] && slot_seq_reg[i] == expected_reg)
            begin
                hit_exp = 1'b1;
                idx_exp = IW'(i);
            end
            if (!slot_valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign out_free  = !out_valid_reg || !res_stall;
    assign main_act  = srb_pkg::classify(flags_reg, z2c_reg);
    assign drain_act = srb_pkg::classify(slot_flags_reg[idx_exp], z2c_reg);
    assign close_trk = (track_reg != srb_pkg::TRK_OFF) ? srb_pkg::TRK_ON : srb_pkg::TRK_OFF;

    // window test: ahead within the cutoff, or behind far enough to be a wrap
    assign s17   = {1'b0, seq_reg};
    assign e17   = {1'b0, expected_reg};
    assign ahead = (s17 > e17 && s17 < e17 + (SW+1)'(srb_pkg::WRAP_CUTOFF)) ||
                   (e17 >= (SW+1)'(srb_pkg::WRAP_CUTOFF) &&
                    s17 < e17 - (SW+1)'(srb_pkg::WRAP_CUTOFF));

    // nearest cached distance, one slot per cycle
    assign scan_d    = slot_seq_reg[scan_idx_reg] - expected_reg;
    assign scan_cand = (slot_valid_reg[scan_idx_reg] && {1'b0, scan_d} < best_reg) ?
                       {1'b0, scan_d} : best_reg;

    // status to the controller
    always_comb
    begin
        sts.has_seq     = has_seq_reg;
        sts.main_close  = (expected_reg == seq_reg) && (main_act == srb_pkg::ACT_CLOSING);
        sts.occ_zero    = (occ_reg == '0);
        sts.give_up     = (int'(occ_reg) >= int'(gu_reg)) && !hit_exp;
        sts.scan_last   = (scan_idx_reg == IW'(D - 1));
        sts.drain_hit   = hit_exp;
        sts.drain_close = (drain_act == srb_pkg::ACT_CLOSING);
        sts.put_ok      = !pend_valid_reg || out_free;
        sts.out_free    = out_free;
    end

    // carry out the operation
    always_comb
    begin
        expected_next = expected_reg;
        known_next    = known_reg;
        track_next    = track_reg;
        gu_next       = gu_reg;
        z2c_next      = z2c_reg;
        occ_next      = occ_reg;
        best_next     = best_reg;
        scan_idx_next = scan_idx_reg;
        put_en        = 1'b0;
        put_act       = srb_pkg::ACT_PAYLOAD;
        put_tag       = tag_reg;
        put_seq       = seq_reg;
        put_exp       = expected_reg;
        put_trk       = track_reg;
        slot_upd      = 1'b0;
        slot_new      = 1'b0;
        slot_clr      = 1'b0;
        wr_idx        = idx_in;

        // register writes
        if (cfg_valid)
        begin
            case (cfg_index)
                srb_pkg::CFG_GIVE_UP:  gu_next = cfg_data;
                srb_pkg::CFG_ZONE:     z2c_next = cfg_data[0];
                srb_pkg::CFG_TRACKING: track_next = {1'b0, cfg_data[0]};
                default: ;
            endcase
        end

        case (cmd.op)
            srb_pkg::OP_PRE:
            begin
                if (!has_seq_reg)
                begin
                    put_en  = 1'b1;
                    put_act = flags_reg[srb_pkg::F_OPC] ? srb_pkg::ACT_PAYLOAD :
                                                          srb_pkg::ACT_NO_OPC;
                    put_seq = '0;
                end
                else if (start_reg && !flags_reg[srb_pkg::F_CLO] &&
                         track_reg != srb_pkg::TRK_LATCHED)
                begin
                    expected_next = seq_reg;
                    known_next    = 1'b1;
                    if (z2c_reg && track_reg != srb_pkg::TRK_OFF)
                    begin
                        track_next = srb_pkg::TRK_LATCHED;
                        put_en     = 1'b1;
                        put_act    = srb_pkg::ACT_LOCK;
                        put_exp    = seq_reg;
                        put_trk    = srb_pkg::TRK_LATCHED;
                    end
                end
                else if (!known_reg && track_reg == srb_pkg::TRK_OFF &&
                         !flags_reg[srb_pkg::F_CHI] && !flags_reg[srb_pkg::F_CLO] &&
                         z2c_reg)
                begin
                    expected_next = seq_reg;
                    known_next    = 1'b1;
                end
            end
            srb_pkg::OP_MAIN:
            begin
                put_en = 1'b1;
                if (expected_reg == seq_reg)
                begin
                    expected_next = seq_reg + SW'(1);
                    put_exp       = seq_reg + SW'(1);
                    put_act       = main_act;
                    if (main_act == srb_pkg::ACT_CLOSING)
                    begin
                        track_next = close_trk;
                        put_trk    = close_trk;
                    end
                end
                else if (!ahead)
                    put_act = srb_pkg::ACT_STALE;
                else if (hit_in)
                begin
                    if (dv_reg)
                    begin
                        slot_upd = 1'b1;
                        put_act  = srb_pkg::ACT_REPLACED;
                    end
                    else
                        put_act = srb_pkg::ACT_STALE;
                end
                else if (free_any)
                begin
                    slot_upd = 1'b1;
                    slot_new = 1'b1;
                    wr_idx   = free_idx;
                    occ_next = occ_reg + OW'(1);
                    put_act  = srb_pkg::ACT_CACHED;
                end
                else
                    put_act = srb_pkg::ACT_OVERFLOW;
            end
            srb_pkg::OP_SCAN_INIT:
            begin
                best_next     = {1'b1, {SW{1'b0}}};
                scan_idx_next = '0;
            end
            srb_pkg::OP_SCAN:
            begin
                if (scan_idx_reg == IW'(D - 1))
                    expected_next = expected_reg + scan_cand[SW-1:0];
                else
                begin
                    best_next     = scan_cand;
                    scan_idx_next = scan_idx_reg + IW'(1);
                end
            end
            srb_pkg::OP_DSTEP:
            begin
                put_en  = 1'b1;
                put_act = drain_act;
                put_tag = slot_tag_reg[idx_exp];
                put_seq = slot_seq_reg[idx_exp];
                if (drain_act == srb_pkg::ACT_CLOSING)
                begin
                    track_next = close_trk;
                    put_trk    = close_trk;
                end
                else
                begin
                    slot_clr      = 1'b1;
                    occ_next      = occ_reg - OW'(1);
                    expected_next = expected_reg + SW'(1);
                    put_exp       = expected_reg + SW'(1);
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg   <= '0;
            known_reg      <= 1'b0;
            track_reg      <= srb_pkg::TRK_OFF;
            gu_reg         <= srb_pkg::GU_W'(32);
            z2c_reg        <= 1'b0;
            occ_reg        <= '0;
            slot_valid_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            expected_reg <= expected_next;
            known_reg    <= known_next;
            track_reg    <= track_next;
            gu_reg       <= gu_next;
            z2c_reg      <= z2c_next;
            occ_reg      <= occ_next;
            if (slot_new)
                slot_valid_reg[wr_idx] <= 1'b1;
            if (slot_clr)
                slot_valid_reg[idx_exp] <= 1'b0;
            if (put_en)
                pend_valid_reg <= 1'b1;
            else if (cmd.op == srb_pkg::OP_FIN)
                pend_valid_reg <= 1'b0;
            if (push)
                out_valid_reg <= 1'b1;
            else if (!res_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // move the pending result to the output on a new result or at the end
    assign push = (put_en && pend_valid_reg) || (cmd.op == srb_pkg::OP_FIN);

    // payload registers
    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        scan_idx_reg <= scan_idx_next;
        if (cmd.op == srb_pkg::OP_LOAD)
        begin
            tag_reg     <= packet_tag;
            has_seq_reg <= has_seq;
            seq_reg     <= seq_num;
            start_reg   <= seq_start;
            flags_reg   <= {has_opcode, closing_lo, closing_hi, is_fragment, has_ack_seq};
            dv_reg      <= data_valid;
        end
        if (slot_upd)
        begin
            slot_tag_reg[wr_idx]   <= tag_reg;
            slot_flags_reg[wr_idx] <= flags_reg;
            if (slot_new)
                slot_seq_reg[wr_idx] <= seq_reg;
        end
        if (put_en)
        begin
            pend_act_reg <= put_act;
            pend_tag_reg <= put_tag;
            pend_seq_reg <= put_seq;
            pend_exp_reg <= put_exp;
            pend_trk_reg <= put_trk;
        end
        if (push)
        begin
            out_act_reg  <= pend_act_reg;
            out_tag_reg  <= pend_tag_reg;
            out_seq_reg  <= pend_seq_reg;
            out_exp_reg  <= pend_exp_reg;
            out_trk_reg  <= pend_trk_reg;
            out_last_reg <= (cmd.op == srb_pkg::OP_FIN);
        end
    end

    assign res_valid      = out_valid_reg;
    assign action         = out_act_reg;
    assign out_tag        = out_tag_reg;
    assign out_seq        = out_seq_reg;
    assign expected_seq   = out_exp_reg;
    assign tracking_level = out_trk_reg;
    assign last           = out_last_reg;

endmodule
`default_nettype wire

// File: bench/sequence_reorder_buffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_tb: self-checking bench for the reorder buffer
// Drives packet descriptors with random idling, stalls the result side,
// predicts every result beat in a scoreboard class and compares each
// accepted beat field by field, across several register settings.
// ----------------------------------------------------------------------------

typedef struct {
    logic [7:0]  tag;
    logic        has_seq;
    logic [15:0] seq;
    logic        start;
    logic        chi;
    logic        clo;
    logic        ack;
    logic        frag;
    logic        opc;
    logic        dvalid;
} pkt_t;

typedef struct {
    logic [3:0]  action;
    logic [7:0]  tag;
    logic [15:0] seq;
    logic [15:0] exp_seq;
    logic [1:0]  trk;
    logic        last;
} beat_t;

class reorder_scoreboard;
    int unsigned give_up;
    logic        zone;
    logic        tracking;
    logic [15:0] expected;
    logic        seq_known;
    logic [1:0]  trk;
    logic        slot_valid [32];
    logic [15:0] slot_seq [32];
    logic [7:0]  slot_tag [32];
    logic [4:0]  slot_flags [32];
    beat_t       pending_beats[$];
    beat_t       step_beats[$];
    int          failures;

    function new();
        give_up = 32;
        zone = 0;
        tracking = 0;
        expected = 0;
        seq_known = 0;
        trk = srb_pkg::TRK_OFF;
        failures = 0;
        foreach (slot_valid[i]) slot_valid[i] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [5:0] data);
        if (idx == srb_pkg::CFG_GIVE_UP)
            give_up = data;
        else if (idx == srb_pkg::CFG_ZONE)
            zone = data[0];
        else if (idx == srb_pkg::CFG_TRACKING)
        begin
            tracking = data[0];
            trk = {1'b0, data[0]};
        end
    endfunction

    function void emit(logic [3:0] act, logic [7:0] tag, logic [15:0] seq);
        beat_t b;
        b.action = act;
        b.tag = tag;
        b.seq = seq;
        b.exp_seq = expected;
        b.trk = trk;
        b.last = 0;
        step_beats.push_back(b);
    endfunction

    function int find_seq(logic [15:0] s);
        for (int i = 0; i < 32; i++)
            if (slot_valid[i] && slot_seq[i] == s)
                return i;
        return -1;
    endfunction

    function int occupancy();
        int c;
        c = 0;
        foreach (slot_valid[i]) if (slot_valid[i]) c++;
        return c;
    endfunction

    function logic [3:0] delivery_action(logic [4:0] f);
        if (!f[srb_pkg::F_ACK] && !f[srb_pkg::F_FRAG] && !f[srb_pkg::F_CHI])
            return srb_pkg::ACT_PING;
        if (f[srb_pkg::F_CHI] && f[srb_pkg::F_CLO] && zone)
            return srb_pkg::ACT_CLOSING;
        if (f[srb_pkg::F_FRAG])
            return srb_pkg::ACT_FRAGMENT;
        return f[srb_pkg::F_OPC] ? srb_pkg::ACT_PAYLOAD : srb_pkg::ACT_NO_OPC;
    endfunction

    // release cached successors in order, skipping a gap at the give-up level
    function void drain_cache();
        int idx;
        int best;
        int d;
        logic [3:0] act;
        idx = find_seq(expected);
        if (occupancy() >= give_up && idx < 0)
        begin
            best = 32'h10000;
            for (int i = 0; i < 32; i++)
                if (slot_valid[i])
                begin
                    d = 16'(slot_seq[i] - expected);
                    if (d < best) best = d;
                end
            if (best < 32'h10000) expected = 16'(expected + best);
            idx = find_seq(expected);
        end
        for (int g = 0; idx >= 0 && g < 32; g++)
        begin
            act = delivery_action(slot_flags[idx]);
            if (act == srb_pkg::ACT_CLOSING)
            begin
                if (trk != srb_pkg::TRK_OFF) trk = srb_pkg::TRK_ON;
                emit(act, slot_tag[idx], slot_seq[idx]);
                break;
            end
            slot_valid[idx] = 0;
            expected = 16'(expected + 1);
            emit(act, slot_tag[idx], slot_seq[idx]);
            idx = find_seq(expected);
        end
    endfunction

    function void note_packet(pkt_t p);
        logic [4:0] flags;
        logic [3:0] act;
        int s;
        int e;
        int idx;
        bit ahead;
        bit closed;
        closed = 0;
        step_beats.delete();
        flags = {p.opc, p.clo, p.chi, p.frag, p.ack};
        if (!p.has_seq)
            emit(p.opc ? srb_pkg::ACT_PAYLOAD : srb_pkg::ACT_NO_OPC, p.tag, 16'd0);
        else
        begin
            if (p.start && !p.clo && trk != srb_pkg::TRK_LATCHED)
            begin
                expected = p.seq;
                seq_known = 1;
                if (zone && trk != srb_pkg::TRK_OFF)
                begin
                    trk = srb_pkg::TRK_LATCHED;
                    emit(srb_pkg::ACT_LOCK, p.tag, p.seq);
                end
            end
            else if (!seq_known && trk == srb_pkg::TRK_OFF && !p.chi && !p.clo && zone)
            begin
                expected = p.seq;
                seq_known = 1;
            end
            if (expected == p.seq)
            begin
                act = delivery_action(flags);
                expected = 16'(p.seq + 1);
                if (act == srb_pkg::ACT_CLOSING)
                begin
                    if (trk != srb_pkg::TRK_OFF) trk = srb_pkg::TRK_ON;
                    closed = 1;
                end
                emit(act, p.tag, p.seq);
            end
            else
            begin
                s = p.seq;
                e = expected;
                ahead = (s > e && s < e + 1024) || (e >= 1024 && s < e - 1024);
                if (!ahead)
                    emit(srb_pkg::ACT_STALE, p.tag, p.seq);
                else
                begin
                    idx = find_seq(p.seq);
                    if (idx >= 0)
                    begin
                        if (p.dvalid)
                        begin
                            slot_tag[idx] = p.tag;
                            slot_flags[idx] = flags;
                            emit(srb_pkg::ACT_REPLACED, p.tag, p.seq);
                        end
                        else
                            emit(srb_pkg::ACT_STALE, p.tag, p.seq);
                    end
                    else
                    begin
                        idx = -1;
                        for (int i = 31; i >= 0; i--)
                            if (!slot_valid[i]) idx = i;
                        if (idx < 0)
                            emit(srb_pkg::ACT_OVERFLOW, p.tag, p.seq);
                        else
                        begin
                            slot_valid[idx] = 1;
                            slot_seq[idx] = p.seq;
                            slot_tag[idx] = p.tag;
                            slot_flags[idx] = flags;
                            emit(srb_pkg::ACT_CACHED, p.tag, p.seq);
                        end
                    end
                end
            end
            if (!closed && occupancy() > 0) drain_cache();
        end
        step_beats[step_beats.size()-1].last = 1;
        foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
    endfunction

    function void check_result(beat_t got);
        beat_t want;
        if (pending_beats.size() == 0)
        begin
            $display("%0t: unexpected result beat action=%0d tag=%0d seq=%0d",
                     $time, got.action, got.tag, got.seq);
            failures++;
            return;
        end
        want = pending_beats.pop_front();
        if (got.action !== want.action)
            $display("%0t: action expected %0d actual %0d", $time, want.action, got.action);
        if (got.tag !== want.tag)
            $display("%0t: out_tag expected %0d actual %0d", $time, want.tag, got.tag);
        if (got.seq !== want.seq)
            $display("%0t: out_seq expected %0d actual %0d", $time, want.seq, got.seq);
        if (got.exp_seq !== want.exp_seq)
            $display("%0t: expected_seq expected %0d actual %0d",
                     $time, want.exp_seq, got.exp_seq);
        if (got.trk !== want.trk)
            $display("%0t: tracking_level expected %0d actual %0d", $time, want.trk, got.trk);
        if (got.last !== want.last)
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        if (got.action !== want.action || got.tag !== want.tag || got.seq !== want.seq ||
            got.exp_seq !== want.exp_seq || got.trk !== want.trk || got.last !== want.last)
            failures++;
    endfunction
endclass

module sequence_reorder_buffer_tb;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    wire         cfg_ready;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;
    logic        pkt_valid;
    wire         pkt_stall;
    logic [7:0]  packet_tag;
    logic        has_seq;
    logic [15:0] seq_num;
    logic        seq_start;
    logic        closing_hi;
    logic        closing_lo;
    logic        has_ack_seq;
    logic        is_fragment;
    logic        has_opcode;
    logic        data_valid;
    wire         res_valid;
    logic        res_stall;
    wire [3:0]   action;
    wire [7:0]   out_tag;
    wire [15:0]  out_seq;
    wire [15:0]  expected_seq;
    wire [1:0]   tracking_level;
    wire         last;

    reorder_scoreboard sb;
    int          send_idle_pct;
    int          stall_pct;
    int          hold_cycles;
    int          cycles;

    sequence_reorder_buffer dut (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // end the run if it hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stall the result side, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            res_stall = 1'b1;
        end
        else
            res_stall = ($urandom_range(0, 99) < stall_pct);
    end

    // check every result beat
    always @(posedge clk)
    begin
        beat_t b;
        if (rst_n && res_valid && !res_stall)
        begin
            b.action = action;
            b.tag = out_tag;
            b.seq = out_seq;
            b.exp_seq = expected_seq;
            b.trk = tracking_level;
            b.last = last;
            sb.check_result(b);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_pkt(input pkt_t p);
        int gap;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            pkt_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        packet_tag = p.tag;
        has_seq = p.has_seq;
        seq_num = p.seq;
        seq_start = p.start;
        closing_hi = p.chi;
        closing_lo = p.clo;
        has_ack_seq = p.ack;
        is_fragment = p.frag;
        has_opcode = p.opc;
        data_valid = p.dvalid;
        pkt_valid = 1'b1;
        do @(posedge clk); while (pkt_stall);
        sb.note_packet(p);
        @(negedge clk);
    endtask

    function automatic pkt_t make_pkt(logic [7:0] tag, logic hs, logic [15:0] seq,
                                      logic [6:0] fl);
        pkt_t p;
        p.tag = tag;
        p.has_seq = hs;
        p.seq = seq;
        {p.start, p.chi, p.clo, p.ack, p.frag, p.opc, p.dvalid} = fl;
        return p;
    endfunction

    function automatic pkt_t random_pkt();
        pkt_t p;
        int r;
        r = $urandom_range(0, 99);
        p.tag = $urandom;
        p.has_seq = (r >= 8);
        if (r < 70)
            p.seq = 16'(sb.expected + $urandom_range(0, 10));
        else if (r < 80)
            p.seq = 16'(sb.expected - $urandom_range(1, 5));
        else if (r < 88)
            p.seq = $urandom;
        else
            p.seq = 16'(sb.expected + $urandom_range(1000, 1030));
        p.start = ($urandom_range(0, 99) < 6);
        p.chi = ($urandom_range(0, 99) < 15);
        p.clo = ($urandom_range(0, 99) < 15);
        p.ack = $urandom_range(0, 1);
        p.frag = ($urandom_range(0, 99) < 30);
        p.opc = ($urandom_range(0, 99) < 80);
        p.dvalid = ($urandom_range(0, 99) < 70);
        return p;
    endfunction

    task automatic wait_idle();
        while (sb.pending_beats.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic run_phase(input logic [5:0] gu, input logic z, input logic t,
                             input int idle, input int stall, input bit pressure);
        write_reg(srb_pkg::CFG_GIVE_UP, gu);
        write_reg(srb_pkg::CFG_ZONE, {5'd0, z});
        write_reg(srb_pkg::CFG_TRACKING, {5'd0, t});
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < 34; i++)
        begin
            if (pressure && i == 4) hold_cycles = 400;
            send_pkt(random_pkt());
        end
        pkt_valid = 1'b0;
        wait_idle();
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pkt_valid = 1'b0;
        packet_tag = '0;
        has_seq = 1'b0;
        seq_num = '0;
        seq_start = 1'b0;
        closing_hi = 1'b0;
        closing_lo = 1'b0;
        has_ack_seq = 1'b0;
        is_fragment = 1'b0;
        has_opcode = 1'b0;
        data_valid = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: flags {start, chi, clo, ack, frag, opc, dvalid}
        send_pkt(make_pkt(8'd255, 0, 16'hFFFF, 7'b0000010)); // unsequenced payload
        send_pkt(make_pkt(8'd0, 0, 16'd7, 7'b0000000));      // unsequenced, no opcode
        send_pkt(make_pkt(8'd1, 1, 16'd0, 7'b0000010));      // ping
        send_pkt(make_pkt(8'd2, 1, 16'd1, 7'b0001010));      // payload
        send_pkt(make_pkt(8'd3, 1, 16'd2, 7'b0000110));      // fragment
        send_pkt(make_pkt(8'd4, 1, 16'd3, 7'b0001000));      // no opcode
        send_pkt(make_pkt(8'd5, 1, 16'd6, 7'b0001011));      // cached
        send_pkt(make_pkt(8'd6, 1, 16'd6, 7'b0001010));      // invalid repeat
        send_pkt(make_pkt(8'd7, 1, 16'd6, 7'b0001001));      // replaced, no opcode
        send_pkt(make_pkt(8'd8, 1, 16'hFFFF, 7'b0111111));   // stale
        send_pkt(make_pkt(8'd9, 1, 16'd5, 7'b0001011));      // cached
        send_pkt(make_pkt(8'd10, 1, 16'd4, 7'b0001011));     // drain two
        send_pkt(make_pkt(8'd11, 1, 16'd1031, 7'b0001011));  // too far ahead
        pkt_valid = 1'b0;
        wait_idle();
        write_reg(srb_pkg::CFG_ZONE, 6'd1);
        write_reg(srb_pkg::CFG_TRACKING, 6'd1);
        write_reg(2'd3, 6'h3F);                              // unused index
        send_pkt(make_pkt(8'd12, 1, 16'hFFFE, 7'b1001011));  // start, lock client
        send_pkt(make_pkt(8'd13, 1, 16'd0, 7'b0111011));     // cached closing
        send_pkt(make_pkt(8'd14, 1, 16'hFFFF, 7'b0001011));  // drain stops at closing
        send_pkt(make_pkt(8'd15, 1, 16'd1, 7'b0001011));     // closing reported again
        send_pkt(make_pkt(8'd16, 1, 16'd0, 7'b0111011));     // expected closing
        pkt_valid = 1'b0;
        wait_idle();

        run_phase(6'd32, 0, 0, 0, 0, 0);
        run_phase(6'd1, 1, 1, 75, 0, 0);
        run_phase(6'd63, 0, 1, 0, 75, 0);
        run_phase(6'd8, 1, 0, 19, 19, 0);
        run_phase(6'd0, 1, 1, 0, 0, 1);
        run_phase(6'd16, 0, 0, 75, 75, 0);

        if (sb.failures == 0 && sb.pending_beats.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
